@@ rtl/vpd_pkg.sv @@
// ----------------------------------------------------------------------------
// vpd_pkg: shared types and constants of the vector pair distance block
// Holds the transfer payload structs, the metric codes and the fixed
// accumulator widths. These widths cover vectors of up to 65536 pairs.
// ----------------------------------------------------------------------------
package vpd_pkg;

    localparam int METRIC_W = 3;
    localparam int CNT_W    = 17;   // holds up to 65536 pairs
    localparam int TERM_W   = 35;   // one signed per-pair term
    localparam int SQ_W     = 31;   // a*a or b*b
    localparam int SUM_W    = 51;   // signed main sum
    localparam int NORM_W   = 47;   // unsigned sum of squares
    localparam int RAT_W    = 18;   // sum of pair counts
    localparam int NUM_W    = 67;   // dividend, main sum magnitude shifted by 16
    localparam int DEN_W    = 48;   // divisor, product of two roots
    localparam int ROOT_IN_W = 64;
    localparam int ROOT_W   = 32;
    localparam int NROOT_W  = 24;   // root of a norm sum
    localparam int FIFO_DEPTH = 2;

    localparam logic [METRIC_W-1:0] MET_HAMMING   = 3'd0;
    localparam logic [METRIC_W-1:0] MET_MANHATTAN = 3'd1;
    localparam logic [METRIC_W-1:0] MET_EUCLIDEAN = 3'd2;
    localparam logic [METRIC_W-1:0] MET_MATCHING  = 3'd3;
    localparam logic [METRIC_W-1:0] MET_JACCARD   = 3'd4;
    localparam logic [METRIC_W-1:0] MET_COSINE    = 3'd5;

    localparam logic signed [15:0] Q_ZERO = 16'sh0000;
    localparam logic signed [15:0] Q_ONE  = 16'sh0100;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] distance;
        logic               no_denominator;
        logic               length_overflow;
    } result_t;

    // Closed sums of one vector pair, handed from the front to the back.
    typedef struct packed {
        logic [METRIC_W-1:0]     metric;
        logic signed [SUM_W-1:0] main_sum;
        logic [NORM_W-1:0]       norm_sum_a;
        logic [NORM_W-1:0]       norm_sum_b;
        logic [CNT_W-1:0]        count_zero_zero;
        logic [CNT_W-1:0]        count_zero_one;
        logic [CNT_W-1:0]        count_one_zero;
        logic [CNT_W-1:0]        count_one_one;
        logic                    overflow;
    } snap_t;

endpackage

@@ rtl/vpd_front.sv @@
// ----------------------------------------------------------------------------
// vpd_front: per-pair accumulator
// Forms the per-pair terms in one stage and adds them into the sums in the
// next. The pair marked last closes the sums into a snapshot for the back.
// ----------------------------------------------------------------------------
module vpd_front
    import vpd_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  item_t               item,
    input  logic [METRIC_W-1:0] metric,
    input  logic [1:0]          fifo_count,
    output logic                full,
    output logic                snap_push,
    output snap_t               snap
);

    logic                     s1_vld_reg;
    logic                     s1_last_reg;
    logic [METRIC_W-1:0]      s1_metric_reg;
    logic signed [TERM_W-1:0] s1_term_reg;
    logic [SQ_W-1:0]          s1_sqa_reg;
    logic [SQ_W-1:0]          s1_sqb_reg;
    logic                     s1_z00_reg, s1_z01_reg, s1_z10_reg, s1_z11_reg;

    logic signed [SUM_W-1:0]  main_reg, main_next;
    logic [NORM_W-1:0]        na_reg, na_next, nb_reg, nb_next;
    logic [CNT_W-1:0]         c00_reg, c00_next, c01_reg, c01_next;
    logic [CNT_W-1:0]         c10_reg, c10_next, c11_reg, c11_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;

    logic                     accept, take;
    logic signed [16:0]       diff;
    logic [16:0]              abs_diff;
    logic signed [33:0]       sq_diff;
    logic signed [31:0]       prod_ab, prod_aa, prod_bb;
    logic signed [TERM_W-1:0] term;

    // A closing pair in the first stage still has to land in the queue.
    assign full   = ({1'b0, fifo_count} + {2'b00, s1_vld_reg & s1_last_reg})
                    >= 3'(FIFO_DEPTH);
    assign accept = push & ~full;

    always_comb
    begin
        diff     = {item.elem_a[15], item.elem_a} - {item.elem_b[15], item.elem_b};
        abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
        sq_diff  = diff * diff;
        prod_ab  = item.elem_a * item.elem_b;
        prod_aa  = item.elem_a * item.elem_a;
        prod_bb  = item.elem_b * item.elem_b;
        case (metric)
            MET_HAMMING:   term = (item.elem_a != item.elem_b) ? TERM_W'(1) : '0;
            MET_MANHATTAN: term = signed'({{(TERM_W-17){1'b0}}, abs_diff});
            MET_EUCLIDEAN: term = TERM_W'(sq_diff);
            MET_COSINE:    term = TERM_W'(prod_ab);
            default:       term = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg   <= item.last;
            s1_metric_reg <= metric;
            s1_term_reg   <= term;
            s1_sqa_reg    <= prod_aa[SQ_W-1:0];
            s1_sqb_reg    <= prod_bb[SQ_W-1:0];
            s1_z00_reg    <= (item.elem_a == Q_ZERO) && (item.elem_b == Q_ZERO);
            s1_z01_reg    <= (item.elem_a == Q_ZERO) && (item.elem_b == Q_ONE);
            s1_z10_reg    <= (item.elem_a == Q_ONE)  && (item.elem_b == Q_ZERO);
            s1_z11_reg    <= (item.elem_a == Q_ONE)  && (item.elem_b == Q_ONE);
        end
    end

    // Pairs past the length limit are dropped and only flagged.
    assign take = s1_vld_reg && (cnt_reg < CNT_W'(MAX_LENGTH));

    always_comb
    begin
        main_next = main_reg;
        na_next   = na_reg;
        nb_next   = nb_reg;
        c00_next  = c00_reg;
        c01_next  = c01_reg;
        c10_next  = c10_reg;
        c11_next  = c11_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg | (s1_vld_reg & ~take);
        if (take)
        begin
            main_next = main_reg + SUM_W'(s1_term_reg);
            na_next   = na_reg + NORM_W'(s1_sqa_reg);
            nb_next   = nb_reg + NORM_W'(s1_sqb_reg);
            c00_next  = c00_reg + CNT_W'(s1_z00_reg);
            c01_next  = c01_reg + CNT_W'(s1_z01_reg);
            c10_next  = c10_reg + CNT_W'(s1_z10_reg);
            c11_next  = c11_reg + CNT_W'(s1_z11_reg);
            cnt_next  = cnt_reg + CNT_W'(1);
        end
    end

    assign snap_push            = s1_vld_reg & s1_last_reg;
    assign snap.metric          = s1_metric_reg;
    assign snap.main_sum        = main_next;
    assign snap.norm_sum_a      = na_next;
    assign snap.norm_sum_b      = nb_next;
    assign snap.count_zero_zero = c00_next;
    assign snap.count_zero_one  = c01_next;
    assign snap.count_one_zero  = c10_next;
    assign snap.count_one_one   = c11_next;
    assign snap.overflow        = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg <= '0;
            na_reg   <= '0;
            nb_reg   <= '0;
            c00_reg  <= '0;
            c01_reg  <= '0;
            c10_reg  <= '0;
            c11_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (snap_push)
        begin
            main_reg <= '0;
            na_reg   <= '0;
            nb_reg   <= '0;
            c00_reg  <= '0;
            c01_reg  <= '0;
            c10_reg  <= '0;
            c11_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            main_reg <= main_next;
            na_reg   <= na_next;
            nb_reg   <= nb_next;
            c00_reg  <= c00_next;
            c01_reg  <= c01_next;
            c10_reg  <= c10_next;
            c11_reg  <= c11_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

@@ rtl/vpd_fifo.sv @@
// ----------------------------------------------------------------------------
// vpd_fifo: snapshot queue between front and back
// A two-entry queue of closed sums so both sides can stall on their own.
// ----------------------------------------------------------------------------
module vpd_fifo
    import vpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  snap_t      wr_data,
    input  logic       rd,
    output snap_t      rd_data,
    output logic       empty,
    output logic [1:0] count
);

    snap_t      mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty   = (count_reg == 2'd0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

@@ rtl/vpd_isqrt.sv @@
// ----------------------------------------------------------------------------
// vpd_isqrt: iterative integer square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vpd_isqrt
    import vpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ROOT_IN_W-1:0] value,
    output logic                 done,
    output logic [ROOT_W-1:0]    root
);

    logic [ROOT_IN_W-1:0] v_reg, res_reg, bit_reg, trial;
    logic                 run_reg, done_reg;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (bit_reg == ROOT_IN_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (bit_reg == ROOT_IN_W'(1)))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

@@ rtl/vpd_div.sv @@
// ----------------------------------------------------------------------------
// vpd_div: restoring divider
// Unsigned quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpd_div
    import vpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]     rem_reg, rem_shift;
    logic [NUM_W-1:0]   quo_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               run_reg, done_reg, last_step;

    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign last_step = (step_reg == STEP_W'(NUM_W - 1));
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_reg <= rem_shift - {1'b0, den_reg};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ rtl/vpd_back.sv @@
// ----------------------------------------------------------------------------
// vpd_back: result sequencer
// Takes one snapshot at a time, runs the root and divide units as the
// metric needs, and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module vpd_back
    import vpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  snap_t   snap,
    input  logic    snap_empty,
    output logic    snap_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQA  = 3'd1;
    localparam logic [2:0] ST_SQB  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [METRIC_W-1:0]     metric_reg;
    logic signed [SUM_W-1:0] main_reg;
    logic [NORM_W-1:0]       nb_reg;
    logic                    ovf_reg;
    logic [NROOT_W-1:0]      ra_reg;
    logic [DEN_W-1:0]        den_reg;
    logic signed [31:0]      dist_reg, dist_next;
    logic                    nodiv_reg, nodiv_next;
    logic                    res_vld_reg;
    result_t                 result_reg;

    logic                    sq_start, sq_done, div_start, div_done;
    logic [ROOT_IN_W-1:0]    sq_val;
    logic [ROOT_W-1:0]       sq_root;
    logic [NUM_W-1:0]        div_num, quo;
    logic [DEN_W-1:0]        div_den;
    logic [RAT_W-1:0]        rat_num, rat_den;
    logic [SUM_W-1:0]        mag;
    logic [16:0]             q_clamp;
    logic                    out_free;

    vpd_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_val),
        .done  (sq_done),
        .root  (sq_root)
    );

    vpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (quo)
    );

    assign out_free = ~res_vld_reg | pop;
    assign mag      = main_reg[SUM_W-1] ? SUM_W'(-main_reg) : SUM_W'(main_reg);
    assign q_clamp  = (quo > NUM_W'(65536)) ? 17'd65536 : quo[16:0];

    always_comb
    begin
        if (snap.metric == MET_JACCARD)
        begin
            rat_num = RAT_W'(snap.count_one_one);
        end
        else
        begin
            rat_num = RAT_W'(snap.count_zero_zero) + RAT_W'(snap.count_one_one);
        end
        rat_den = rat_num + RAT_W'(snap.count_zero_one) + RAT_W'(snap.count_one_zero);
    end

    always_comb
    begin
        state_next = state_reg;
        dist_next  = dist_reg;
        nodiv_next = nodiv_reg;
        snap_pop   = 1'b0;
        sq_start   = 1'b0;
        sq_val     = ROOT_IN_W'(snap.main_sum);
        div_start  = 1'b0;
        div_num    = NUM_W'({rat_num, 16'h0000});
        div_den    = DEN_W'(rat_den);
        case (state_reg)
            ST_IDLE:
            begin
                if (!snap_empty)
                begin
                    snap_pop   = 1'b1;
                    nodiv_next = 1'b0;
                    dist_next  = '0;
                    state_next = ST_DONE;
                    case (snap.metric)
                        MET_HAMMING:
                        begin
                            dist_next = snap.main_sum[31:0];
                        end
                        MET_MANHATTAN:
                        begin
                            // Signed compare: a sum mixed with other metric
                            // terms can be negative and is then passed through.
                            if (snap.main_sum > $signed(SUM_W'(32'h7FFF_FFFF)))
                            begin
                                dist_next = 32'sh7FFF_FFFF;
                            end
                            else
                            begin
                                dist_next = snap.main_sum[31:0];
                            end
                        end
                        MET_EUCLIDEAN:
                        begin
                            sq_start   = 1'b1;
                            state_next = ST_SQA;
                        end
                        MET_MATCHING, MET_JACCARD:
                        begin
                            if (rat_den == '0)
                            begin
                                nodiv_next = 1'b1;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        MET_COSINE:
                        begin
                            sq_start   = 1'b1;
                            sq_val     = ROOT_IN_W'(snap.norm_sum_a);
                            state_next = ST_SQA;
                        end
                        default:
                        begin
                            dist_next = '0;
                        end
                    endcase
                end
            end
            ST_SQA:
            begin
                if (sq_done)
                begin
                    if (metric_reg == MET_EUCLIDEAN)
                    begin
                        dist_next  = sq_root;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sq_start   = 1'b1;
                        sq_val     = ROOT_IN_W'(nb_reg);
                        state_next = ST_SQB;
                    end
                end
            end
            ST_SQB:
            begin
                if (sq_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (den_reg == '0)
                begin
                    nodiv_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'({mag, 16'h0000});
                    div_den    = den_reg;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (metric_reg == MET_COSINE)
                    begin
                        dist_next = main_reg[SUM_W-1] ? -32'(q_clamp) : 32'(q_clamp);
                    end
                    else
                    begin
                        dist_next = quo[31:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        nodiv_reg <= nodiv_next;
        if (snap_pop)
        begin
            metric_reg <= snap.metric;
            main_reg   <= snap.main_sum;
            nb_reg     <= snap.norm_sum_b;
            ovf_reg    <= snap.overflow;
        end
        if ((state_reg == ST_SQA) && sq_done)
        begin
            ra_reg <= sq_root[NROOT_W-1:0];
        end
        if ((state_reg == ST_SQB) && sq_done)
        begin
            den_reg <= ra_reg * sq_root[NROOT_W-1:0];
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            result_reg.distance        <= dist_reg;
            result_reg.no_denominator  <= nodiv_reg;
            result_reg.length_overflow <= ovf_reg;
        end
    end

    assign empty  = ~res_vld_reg;
    assign result = result_reg;

endmodule

@@ rtl/vector_pair_distance_metrics.sv @@
// Flow: a closing pair's sums are written into the snapshot queue in the cycle
// after its transfer. With an idle back end, Hamming and Manhattan results need
// neither root nor divide, Euclidean takes one root, matching and Jaccard one
// divide, and cosine two roots and a divide.
// Throughput: one element pair per cycle while full is low; one vector pair per back-end run.
// Reset: rst_n clears all control state and the metric register at once.
// ----------------------------------------------------------------------------
// vector_pair_distance_metrics: streaming vector distance unit
// Accumulates element pairs of two vectors and returns one distance per
// vector pair under the configured metric.
// ----------------------------------------------------------------------------
module vector_pair_distance_metrics
    import vpd_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Element pair channel.
    input  logic        push,
    output logic        full,
    input  item_t       item,
    // Result channel.
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The single register sits at byte address zero; address four is
    // outside the map and reads as zero.
    localparam logic REG_METRIC = 1'b0;

    logic [METRIC_W-1:0] metric_reg;
    logic                cfg_write;

    snap_t      front_snap, fifo_head;
    logic       front_push, fifo_pop, fifo_empty;
    logic [1:0] fifo_count;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= MET_HAMMING;
        end
        else if (cfg_write && (paddr[2] == REG_METRIC))
        begin
            metric_reg <= pwdata[METRIC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_METRIC) ? {{(32-METRIC_W){1'b0}}, metric_reg}
                                             : 32'h0000_0000;

    // The front takes one pair per cycle while full is low and closes the sums
    // on the last pair; the metric is sampled with every pair as it enters.
    vpd_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .metric     (metric_reg),
        .fifo_count (fifo_count),
        .full       (full),
        .snap_push  (front_push),
        .snap       (front_snap)
    );

    // The queue lets the front keep streaming while the back finishes the
    // slow root and divide work of an earlier vector pair.
    vpd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (front_push),
        .wr_data (front_snap),
        .rd      (fifo_pop),
        .rd_data (fifo_head),
        .empty   (fifo_empty),
        .count   (fifo_count)
    );

    // The back owns the output register. A waiting result stalls the back,
    // and the front only stalls once the queue has filled behind it.
    vpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (fifo_head),
        .snap_empty (fifo_empty),
        .snap_pop   (fifo_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

@@ rtl/vpd_checker.sv @@
// ----------------------------------------------------------------------------
// vpd_checker: port-level checks of the distance unit
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module vpd_checker
    import vpd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result waiting during reset");

    // A missing denominator always comes with a zero distance.
    a_nodiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.no_denominator) |-> (result.distance == 32'sd0))
        else $error("nonzero distance with missing denominator");

    // A result that is not taken stays on the ports unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind vector_pair_distance_metrics vpd_checker u_vpd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

@@ bench/vector_pair_distance_metrics_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_pair_distance_metrics_tb: self-checking bench for the distance unit
// Streams vector pairs under every metric, mixes directed and random element
// pairs, and compares each distance transfer with a built-in predictor.
// ----------------------------------------------------------------------------
module vector_pair_distance_metrics_tb;
    import vpd_pkg::*;

    localparam int VEC_MAX = 1024;
    localparam int DRAIN_CYCLES = 400;
    localparam int ITEMS_TOTAL = 1900;
    localparam logic [2:0] REG_METRIC = 3'd0;
    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = -16'sh8000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    item_t       item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vector_pair_distance_metrics u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a copy of the metric register and the running sums
    // of the vector pair that is currently open.
    logic [2:0]          cur_metric;
    logic signed [63:0]  acc_main;
    logic [63:0]         acc_sq_a;
    logic [63:0]         acc_sq_b;
    int unsigned         n_zz, n_zo, n_oz, n_oo, n_pairs;
    bit                  too_long;

    result_t distance_queue[$];
    int      error_count;
    int      results_seen;
    int      vectors_sent;
    int      items_sent;
    bit      quiet_pop;     // disables the consumer's random stalls for a while
    bit      quiet_push;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAIL vector_pair_distance_metrics");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] q16_ratio(input logic [63:0] num,
                                                     input logic [63:0] den,
                                                     ref bit nodiv);
        if (den == 0)
        begin
            nodiv = 1'b1;
            return 0;
        end
        return (num << 16) / den;
    endfunction

    task automatic clear_sums();
        acc_main = 0;
        acc_sq_a = 0;
        acc_sq_b = 0;
        n_zz = 0; n_zo = 0; n_oz = 0; n_oo = 0;
        n_pairs = 0;
        too_long = 1'b0;
    endtask

    // Folds one accepted element pair into the sums and, on a closing pair,
    // queues the distance the unit is expected to return.
    task automatic predict_distance(input item_t it);
        logic signed [63:0] a, b, d, exp_dist;
        logic [63:0] den, mag, q;
        bit nodiv;
        result_t r;
        a = it.elem_a;
        b = it.elem_b;
        d = a - b;
        nodiv = 1'b0;
        if (n_pairs < VEC_MAX)
        begin
            case (cur_metric)
                MET_HAMMING:   if (a != b) acc_main += 1;
                MET_MANHATTAN: acc_main += (d < 0) ? -d : d;
                MET_EUCLIDEAN: acc_main += d * d;
                MET_COSINE:    acc_main += a * b;
                default: ;
            endcase
            acc_sq_a += a * a;
            acc_sq_b += b * b;
            if (a == 0 && b == 0) n_zz++;
            if (a == 0 && b == Q_ONE) n_zo++;
            if (a == Q_ONE && b == 0) n_oz++;
            if (a == Q_ONE && b == Q_ONE) n_oo++;
            n_pairs++;
        end
        else
            too_long = 1'b1;
        if (!it.last)
            return;
        case (cur_metric)
            MET_HAMMING:   exp_dist = acc_main;
            MET_MANHATTAN: exp_dist = (acc_main > 64'sh7fffffff) ? 64'sh7fffffff : acc_main;
            MET_EUCLIDEAN: exp_dist = int_sqrt(acc_main);
            MET_MATCHING:  exp_dist = q16_ratio(n_zz + n_oo, n_zz + n_oo + n_zo + n_oz, nodiv);
            MET_JACCARD:   exp_dist = q16_ratio(n_oo, n_oo + n_zo + n_oz, nodiv);
            MET_COSINE:
            begin
                den = int_sqrt(acc_sq_a) * int_sqrt(acc_sq_b);
                if (den == 0)
                begin
                    nodiv = 1'b1;
                    exp_dist = 0;
                end
                else
                begin
                    mag = (acc_main < 0) ? -acc_main : acc_main;
                    q = (mag << 16) / den;
                    if (q > 65536) q = 65536;
                    exp_dist = (acc_main < 0) ? -$signed(q) : $signed(q);
                end
            end
            default: exp_dist = 0;
        endcase
        r.distance = exp_dist[31:0];
        r.no_denominator = nodiv;
        r.length_overflow = too_long;
        distance_queue = {distance_queue, r};
        clear_sums();
    endtask

    // Consumer: pops at random, samples at the rising edge, compares with
    // the oldest expected distance.
    initial
    begin
        result_t want;
        pop = 1'b0;
        error_count = 0;
        results_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                results_seen++;
                if (distance_queue.size() == 0)
                begin
                    $error("unexpected transfer: distance %0d", result.distance);
                    error_count++;
                end
                else
                begin
                    want = distance_queue.pop_front();
                    if (result.distance !== want.distance)
                    begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, result.distance);
                        error_count++;
                    end
                    if (result.no_denominator !== want.no_denominator)
                    begin
                        $error("no_denominator: expected %0b, got %0b",
                               want.no_denominator, result.no_denominator);
                        error_count++;
                    end
                    if (result.length_overflow !== want.length_overflow)
                    begin
                        $error("length_overflow: expected %0b, got %0b",
                               want.length_overflow, result.length_overflow);
                        error_count++;
                    end
                end
            end
            @(negedge clk);
            pop <= quiet_pop ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    // Drives one element pair and holds it until the transfer happens.
    // Unless quiet_push is set, random idle cycles are inserted before the pair. push
    // stays high on return; the next pair or the next idle wait decides its value.
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last_flag);
        item_t it;
        it.elem_a = a;
        it.elem_b = b;
        it.last = last_flag;
        while (!quiet_push && $urandom_range(99) < 18)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        predict_distance(it);
        items_sent++;
        if (last_flag)
            vectors_sent++;
        @(negedge clk);
    endtask

    // Waits until every expected distance is in, then lets the back stage
    // settle so that a register write never lands mid-computation.
    task automatic wait_idle();
        int guard;
        push <= 1'b0;
        guard = 0;
        while (distance_queue.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write: a setup cycle, then an access cycle.
    task automatic write_metric(input logic [2:0] code);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_METRIC;
        pwdata <= {29'd0, code};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cur_metric = code;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'sh0000;
            1: return Q_ONE;
            2: return $urandom_range(1) ? Q_MAX : Q_MIN;
            3: return $signed(16'($urandom_range(2047))) - 16'sd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
    } row_t;

    // Directed rows. With the metric still at its reset value (Hamming),
    // the typed-in distances below can be read straight off the input.
    row_t directed_rows[] = '{
        '{16'sh0000, 16'sh0000, 1'b1},      // equal pair: distance 0
        '{Q_MAX,     Q_MIN,     1'b1},      // unequal extremes: distance 1
        '{Q_MIN,     Q_MIN,     1'b0},
        '{Q_MAX,     16'sh0000, 1'b0},
        '{16'sh0100, 16'sh0000, 1'b1}       // three pairs, two unequal
    };
    int directed_hamming[] = '{0, 1, 2};

    initial
    begin
        int k, len, phase;
        logic [2:0] met;
        result_t want;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_pop = 1'b0;
        quiet_push = 1'b0;
        vectors_sent = 0;
        items_sent = 0;
        cur_metric = MET_HAMMING;
        clear_sums();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, reset metric: check the typed values on the fly.
        k = 0;
        foreach (directed_rows[i])
        begin
            send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last);
            if (directed_rows[i].last)
            begin
                want = distance_queue[distance_queue.size()-1];
                if (want.distance !== directed_hamming[k])
                begin
                    $error("distance: expected %0d, got %0d",
                           directed_hamming[k], want.distance);
                    error_count++;
                end
                k++;
            end
        end
        wait_idle();

        // Three short directed vectors per metric code, including the unused
        // codes and single-pair vectors that leave no denominator.
        for (int m = 0; m < 8; m++)
        begin
            write_metric(3'(m));
            send_pair(Q_MAX, Q_MIN, 1'b0);
            send_pair(Q_MIN, Q_MAX, 1'b0);
            send_pair(Q_ONE, Q_ONE, 1'b0);
            send_pair(16'sh0000, Q_ONE, 1'b1);
            send_pair(Q_MAX, Q_MAX, 1'b1);           // no binary pairs
            send_pair(16'sh0000, 16'sh0000, 1'b1);   // zero norms for cosine
            wait_idle();
        end

        // Vector longer than the maximum length under Manhattan.
        write_metric(MET_MANHATTAN);
        quiet_push = 1'b1;
        quiet_pop = 1'b1;
        for (int i = 0; i < VEC_MAX + 3; i++)
            send_pair(Q_MAX, Q_MIN, i == VEC_MAX + 2);
        quiet_push = 1'b0;
        quiet_pop = 1'b0;
        wait_idle();

        // Random part: phases of random vectors under varied metrics, the metric
        // written once per phase in the pause between phases, with one phase
        // that runs without random stalls on either side.
        phase = 0;
        while (items_sent < ITEMS_TOTAL)
        begin
            met = (phase < 2) ? 3'(phase * 5) : 3'($urandom_range(7));
            write_metric(met);
            quiet_push = (phase == 3);
            quiet_pop = (phase == 3);
            for (int v = 0; v < 12; v++)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(2) == 0)
                        send_pair(($urandom_range(1) ? Q_ONE : 16'sh0000),
                                  ($urandom_range(1) ? Q_ONE : 16'sh0000), i == len - 1);
                    else
                        send_pair(rand_elem(), rand_elem(), i == len - 1);
                end
            end
            quiet_push = 1'b0;
            quiet_pop = 1'b0;
            wait_idle();
            phase++;
        end

        wait_idle();
        if (distance_queue.size() != 0)
        begin
            $error("%0d expected distances never arrived", distance_queue.size());
            error_count++;
        end
        $display("Covered %0d vector pairs over all metric codes, %0d distance transfers,",
                 vectors_sent, results_seen);
        $display("including extreme elements, empty denominators and an over-long vector.");
        if (error_count == 0)
            $display("PASS vector_pair_distance_metrics");
        else
            $display("FAIL vector_pair_distance_metrics");
        $finish;
    end

endmodule
